/* design/sipp_pkg.sv */
package sipp_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned HIGH_BYTES   = 8;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned OUT_W        = 120;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // type byte codes on the wire
  localparam logic [7:0] MT_REQUEST       = 8'h00;
  localparam logic [7:0] MT_REQUEST_NORET = 8'h01;
  localparam logic [7:0] MT_NOTIFICATION  = 8'h02;
  localparam logic [7:0] MT_RESPONSE      = 8'h80;
  localparam logic [7:0] MT_ERROR         = 8'h81;
  localparam logic [7:0] RC_OK            = 8'h00;

  typedef enum logic [2:0] {
    KIND_REQUEST       = 3'd0,
    KIND_REQUEST_NORET = 3'd1,
    KIND_NOTIFICATION  = 3'd2,
    KIND_RESPONSE      = 3'd3,
    KIND_ERROR         = 3'd4,
    KIND_INVALID       = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    RCLASS_OK      = 2'd0,
    RCLASS_NOT_OK  = 2'd1,
    RCLASS_NA      = 2'd2,
    RCLASS_INVALID = 2'd3
  } rclass_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_t;

  // first member sits in the top bits; svc_id ends up at bit 0
  typedef struct packed {
    status_t     status;
    rclass_t     return_class;
    kind_t       message_kind;
    logic [7:0]  interface_version;
    logic [7:0]  proto_ver;
    logic [15:0] sess_id;
    logic [15:0] clnt_id;
    logic [31:0] pdu_length;
    logic [14:0] method_or_event_id;
    logic        is_event;
    logic [15:0] svc_id;
  } result_t;

endpackage

/* design/sipp_decode.sv */
module sipp_decode (
  input  logic [63:0]            hdr_hi,
  input  logic [63:0]            hdr_lo,
  input  logic [31:0]            cnt,
  output sipp_pkg::result_t      res
);
  import sipp_pkg::*;

  logic [7:0]       type_byte;
  logic [7:0]       rc_byte;
  kind_t            kind;
  logic [CNT_W-1:0] after_len;
  logic             mismatch;
  logic             short_hdr;

  assign type_byte = hdr_lo[15:8];
  assign rc_byte   = hdr_lo[7:0];
  assign after_len = cnt - CNT_W'(HIGH_BYTES);
  assign mismatch  = (cnt == CNT_MAX) || (hdr_hi[31:0] != after_len);
  assign short_hdr = cnt < CNT_W'(HEADER_BYTES);

  always_comb begin
    unique case (type_byte)
      MT_REQUEST:       kind = KIND_REQUEST;
      MT_REQUEST_NORET: kind = KIND_REQUEST_NORET;
      MT_NOTIFICATION:  kind = KIND_NOTIFICATION;
      MT_RESPONSE:      kind = KIND_RESPONSE;
      MT_ERROR:         kind = KIND_ERROR;
      default:          kind = KIND_INVALID;
    endcase
  end

  always_comb begin
    res = '0;
    if (short_hdr) begin
      res.status = ST_SHORT;
    end else begin
      res.svc_id             = hdr_hi[63:48];
      res.is_event           = hdr_hi[47];
      res.method_or_event_id = hdr_hi[46:32];
      res.pdu_length         = hdr_hi[31:0];
      res.clnt_id            = hdr_lo[63:48];
      res.sess_id            = hdr_lo[47:32];
      res.proto_ver          = hdr_lo[31:24];
      res.interface_version  = hdr_lo[23:16];
      res.message_kind       = kind;
      if (kind == KIND_RESPONSE || kind == KIND_ERROR) begin
        res.return_class = (rc_byte == RC_OK) ? RCLASS_OK : RCLASS_NOT_OK;
      end else begin
        res.return_class = (rc_byte == RC_OK) ? RCLASS_NA : RCLASS_INVALID;
      end
      if (mismatch) begin
        res.status = ST_MISMATCH;
      end else if (kind == KIND_INVALID) begin
        res.status = ST_UNKNOWN;
      end else begin
        res.status = ST_OK;
      end
    end
  end

endmodule

/* design/someip_header_parser.sv */
// channel  | dir | handshake                | payload
// s_axis   | in  | s_axis_tvalid/tready     | tdata: data_byte, tlast: last_byte
// m_axis   | out | m_axis_tvalid/tready     | tdata: decoded header + status
//
// One byte per cycle unless stalled; valid rises the cycle after the last byte.
// Header gather, count and decode happen in the accept cycle; only the
// result register follows.
// rst clears the byte counter, header words and the result valid.
// A held result stalls input only when it is not taken in that cycle.
module someip_header_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  input  logic                        s_axis_tlast,  // last_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] svc_id, [16] is_event, [31:17] method_or_event_id,
  // [63:32] pdu_length, [79:64] clnt_id, [95:80] sess_id,
  // [103:96] proto_ver, [111:104] interface_version,
  // [114:112] message_kind, [116:115] return_class, [118:117] status, [119] zero
  output logic [sipp_pkg::OUT_W-1:0] m_axis_tdata
);
  import sipp_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [63:0]      hdr_hi;
  logic [63:0]      hdr_hi_next;
  logic [63:0]      hdr_lo;
  logic [63:0]      hdr_lo_next;
  result_t          dec;
  result_t          res;
  logic             in_acc;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    hdr_hi_next = hdr_hi;
    hdr_lo_next = hdr_lo;
    if (cnt < CNT_W'(HIGH_BYTES)) begin
      hdr_hi_next = {hdr_hi[55:0], s_axis_tdata};
    end else if (cnt < CNT_W'(HEADER_BYTES)) begin
      hdr_lo_next = {hdr_lo[55:0], s_axis_tdata};
    end
    cnt_next = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
  end

  sipp_decode u_decode (
    .hdr_hi (hdr_hi_next),
    .hdr_lo (hdr_lo_next),
    .cnt    (cnt_next),
    .res    (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      hdr_hi        <= '0;
      hdr_lo        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_acc) begin
        if (s_axis_tlast) begin
          cnt           <= '0;
          hdr_hi        <= '0;
          hdr_lo        <= '0;
          m_axis_tvalid <= 1'b1;
        end else begin
          cnt    <= cnt_next;
          hdr_hi <= hdr_hi_next;
          hdr_lo <= hdr_lo_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_axis_tlast) begin
      res <= dec;
    end
  end

  assign m_axis_tdata = {1'b0, res};

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |=> m_axis_tvalid)
    else $error("no result after last byte");

  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tlast |=> cnt == '0 && hdr_hi == '0 && hdr_lo == '0)
    else $error("state not cleared after last byte");

  a_short_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res.status == ST_SHORT |-> m_axis_tdata[116:0] == '0)
    else $error("short header result carries field data");

  a_body_no_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && !s_axis_tlast && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result without last byte");

endmodule
